/* rtl/dalt_pkg.sv */
// ----------------------------------------------------------------------------
// dalt_pkg
// Types and codes shared by the dual-axis light tracker.
// ----------------------------------------------------------------------------
package dalt_pkg;

   localparam int CmdWidth  = 3;
   localparam int LuxWidth  = 16;
   localparam int VertWidth = 15;
   localparam int HorzWidth = 16;
   localparam int CsrIdxWidth  = 3;
   localparam int CsrDataWidth = 16;

   // command codes
   localparam logic [CmdWidth-1:0] CMD_SAMPLE = 3'd0;
   localparam logic [CmdWidth-1:0] CMD_MODE   = 3'd1;
   localparam logic [CmdWidth-1:0] CMD_RIGHT  = 3'd2;
   localparam logic [CmdWidth-1:0] CMD_LEFT   = 3'd3;
   localparam logic [CmdWidth-1:0] CMD_UP     = 3'd4;
   localparam logic [CmdWidth-1:0] CMD_DOWN   = 3'd5;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] REG_LIGHT_THRESHOLD = 3'd0;
   localparam logic [CsrIdxWidth-1:0] REG_MAX_ADJUST      = 3'd1;
   localparam logic [CsrIdxWidth-1:0] REG_MANUAL_STEP     = 3'd2;
   localparam logic [CsrIdxWidth-1:0] REG_VERT_MIN        = 3'd3;
   localparam logic [CsrIdxWidth-1:0] REG_VERT_MAX        = 3'd4;
   localparam logic [CsrIdxWidth-1:0] REG_HORIZ_MIN       = 3'd5;
   localparam logic [CsrIdxWidth-1:0] REG_HORIZ_MAX       = 3'd6;

   typedef struct packed {
      logic [CmdWidth-1:0] command;
      logic [LuxWidth-1:0] lux_top_left;
      logic [LuxWidth-1:0] lux_top_right;
      logic [LuxWidth-1:0] lux_bottom_left;
      logic [LuxWidth-1:0] lux_bottom_right;
   } dalt_req_type;

   typedef struct packed {
      logic                        move_issued;
      logic [VertWidth-1:0]        vert_target;
      logic signed [HorzWidth-1:0] horiz_target;
      logic                        manual_mode;
   } dalt_rsp_type;

endpackage

/* rtl/dual_axis_light_tracker.sv */
// ----------------------------------------------------------------------------
// dual_axis_light_tracker
// Two-axis light tracker: quadrant lux samples steer the axes in auto mode,
// jog commands move the drive targets in manual mode.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (valid/ready) carries one item: a lux sample, the mode
//    button or a manual jog. rsp channel (valid/ready) returns exactly one
//    result item per request item, in order.
//  - csr port: csr_write with csr_index/csr_wdata writes a limit or tuning
//    register; write only while no item is in flight.
//  - Path: an accepted request item waits in the input register and is
//    loaded into the result register once that is empty or rsp_ready is high.
//  - Throughput: one item per cycle while rsp_ready stays high. The whole
//    update of both axes is one combinational pass between the input and
//    result registers; angle state and result load in the same cycle.
//  - Stall: when rsp_ready is low the result holds, the item in the input
//    register waits, and req_ready drops once both registers are full.
//  - Reset: registers return to their defaults, auto mode, vertical angles
//    9000 and horizontal angles 0 centidegrees; both channels empty.
// ----------------------------------------------------------------------------
module dual_axis_light_tracker
   import dalt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  dalt_req_type            req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output dalt_rsp_type            rsp_data,
   input  logic                    csr_write,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata
);

   typedef logic signed [17:0] wide_type;

   // config
   logic [15:0]                 light_threshold_ff;
   logic [13:0]                 max_adjust_ff;
   logic [13:0]                 manual_step_ff;
   logic [VertWidth-1:0]        vert_min_ff;
   logic [VertWidth-1:0]        vert_max_ff;
   logic signed [HorzWidth-1:0] horiz_min_ff;
   logic signed [HorzWidth-1:0] horiz_max_ff;

   // state
   logic [VertWidth-1:0]        auto_vert_ff, auto_vert_in;
   logic signed [HorzWidth-1:0] auto_horiz_ff, auto_horiz_in;
   logic [VertWidth-1:0]        drive_vert_ff, drive_vert_in;
   logic signed [HorzWidth-1:0] drive_horiz_ff, drive_horiz_in;
   logic                        mode_manual_ff, mode_manual_in;

   // pipeline
   logic         in_vld_ff;
   dalt_req_type in_ff;
   logic         out_vld_ff;
   dalt_rsp_type out_ff, out_in;
   logic         advance;

   wide_type tl, tr, bl, br, dv, dh;
   wide_type thr2, cap, step;
   wide_type vmin, vmax, hmin, hmax;
   wide_type av, ah, dvv, dhh, nv, nh, t;
   wide_type mag_v, mag_h, adj_v, adj_h;
   logic     act_v, act_h, moved;
   logic [19:0] mul_v, mul_h;

   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      tl = wide_type'({2'b00, in_ff.lux_top_left});
      tr = wide_type'({2'b00, in_ff.lux_top_right});
      bl = wide_type'({2'b00, in_ff.lux_bottom_left});
      br = wide_type'({2'b00, in_ff.lux_bottom_right});
      dv = (bl + br) - (tl + tr);
      dh = (tr + br) - (tl + bl);

      thr2 = wide_type'({1'b0, light_threshold_ff, 1'b0});
      cap  = wide_type'({4'b0000, max_adjust_ff});
      step = wide_type'({4'b0000, manual_step_ff});
      vmin = wide_type'({3'b000, vert_min_ff});
      vmax = wide_type'({3'b000, vert_max_ff});
      hmin = wide_type'({{2{horiz_min_ff[HorzWidth-1]}}, horiz_min_ff});
      hmax = wide_type'({{2{horiz_max_ff[HorzWidth-1]}}, horiz_max_ff});
      av   = wide_type'({3'b000, auto_vert_ff});
      ah   = wide_type'({{2{auto_horiz_ff[HorzWidth-1]}}, auto_horiz_ff});
      dvv  = wide_type'({3'b000, drive_vert_ff});
      dhh  = wide_type'({{2{drive_horiz_ff[HorzWidth-1]}}, drive_horiz_ff});

      // move size: 5*|d| centidegrees, capped
      mag_v = dv[17] ? -dv : dv;
      mag_h = dh[17] ? -dh : dh;
      act_v = mag_v > thr2;
      act_h = mag_h > thr2;
      mul_v = {1'b0, mag_v[16:0], 2'b00} + {3'b000, mag_v[16:0]};
      mul_h = {1'b0, mag_h[16:0], 2'b00} + {3'b000, mag_h[16:0]};
      adj_v = (mul_v > {6'd0, max_adjust_ff}) ? cap : wide_type'({4'b0000, mul_v[13:0]});
      adj_h = (mul_h > {6'd0, max_adjust_ff}) ? cap : wide_type'({4'b0000, mul_h[13:0]});

      nv = av;
      if (dv > 0 && av < vmax) begin
         nv = av + adj_v;
      end else if (dv < 0 && av > vmin) begin
         nv = av - adj_v;
      end
      nh = ah;
      if (dh > 0 && ah < hmax) begin
         nh = ah + adj_h;
      end else if (dh < 0 && ah > hmin) begin
         nh = ah - adj_h;
      end

      auto_vert_in   = auto_vert_ff;
      auto_horiz_in  = auto_horiz_ff;
      drive_vert_in  = drive_vert_ff;
      drive_horiz_in = drive_horiz_ff;
      mode_manual_in = mode_manual_ff;
      moved          = 1'b0;
      t              = '0;

      unique case (in_ff.command)
         CMD_SAMPLE: begin
            if (!mode_manual_ff) begin
               moved = 1'b1;
               if (act_v && nv > vmin && nv < vmax) begin
                  auto_vert_in = nv[VertWidth-1:0];
               end
               if (act_h && nh >= hmin && nh <= hmax) begin
                  auto_horiz_in = nh[HorzWidth-1:0];
               end
               drive_vert_in  = auto_vert_in;
               drive_horiz_in = auto_horiz_in;
            end
         end
         CMD_MODE: begin
            mode_manual_in = !mode_manual_ff;
         end
         CMD_RIGHT: begin
            if (mode_manual_ff) begin
               moved = 1'b1;
               t = dhh + step;
               drive_horiz_in = (t < hmax) ? t[HorzWidth-1:0] : horiz_max_ff;
            end
         end
         CMD_LEFT: begin
            if (mode_manual_ff) begin
               moved = 1'b1;
               t = dhh - step;
               drive_horiz_in = (t > hmin) ? t[HorzWidth-1:0] : horiz_min_ff;
            end
         end
         CMD_UP: begin
            if (mode_manual_ff) begin
               moved = 1'b1;
               t = dvv + step;
               drive_vert_in = (t < vmax) ? t[VertWidth-1:0] : vert_max_ff;
            end
         end
         CMD_DOWN: begin
            if (mode_manual_ff) begin
               moved = 1'b1;
               t = dvv - step;
               drive_vert_in = (t > vmin) ? t[VertWidth-1:0] : vert_min_ff;
            end
         end
         default: begin
         end
      endcase

      out_in.move_issued  = moved;
      out_in.vert_target  = drive_vert_in;
      out_in.horiz_target = drive_horiz_in;
      out_in.manual_mode  = mode_manual_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         light_threshold_ff <= 16'd5;
         max_adjust_ff      <= 14'd500;
         manual_step_ff     <= 14'd500;
         vert_min_ff        <= 15'd0;
         vert_max_ff        <= 15'd9000;
         horiz_min_ff       <= -16'sd9000;
         horiz_max_ff       <= 16'sd9000;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_LIGHT_THRESHOLD: light_threshold_ff <= csr_wdata;
            REG_MAX_ADJUST:      max_adjust_ff      <= csr_wdata[13:0];
            REG_MANUAL_STEP:     manual_step_ff     <= csr_wdata[13:0];
            REG_VERT_MIN:        vert_min_ff        <= csr_wdata[VertWidth-1:0];
            REG_VERT_MAX:        vert_max_ff        <= csr_wdata[VertWidth-1:0];
            REG_HORIZ_MIN:       horiz_min_ff       <= $signed(csr_wdata);
            REG_HORIZ_MAX:       horiz_max_ff       <= $signed(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_vert_ff   <= 15'd9000;
         auto_horiz_ff  <= '0;
         drive_vert_ff  <= 15'd9000;
         drive_horiz_ff <= '0;
         mode_manual_ff <= 1'b0;
         in_vld_ff      <= 1'b0;
         out_vld_ff     <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            in_vld_ff <= 1'b1;
         end else if (advance) begin
            in_vld_ff <= 1'b0;
         end
         if (advance) begin
            out_vld_ff     <= 1'b1;
            auto_vert_ff   <= auto_vert_in;
            auto_horiz_ff  <= auto_horiz_in;
            drive_vert_ff  <= drive_vert_in;
            drive_horiz_ff <= drive_horiz_in;
            mode_manual_ff <= mode_manual_in;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

endmodule

/* sim/dalt_checker.sv */
// ----------------------------------------------------------------------------
// dalt_checker
// Watches the request, result and register ports of the light tracker,
// keeps its own copy of the tracker angles and limits, and compares every
// result item with the targets predicted for the oldest open request item.
// ----------------------------------------------------------------------------
module dalt_checker
   import dalt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  dalt_req_type            req_data,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  dalt_rsp_type            rsp_data,
   input  logic                    csr_write,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata,
   output int                      open_items,
   output int                      fail_count
);

   logic [15:0]        light_thr;
   logic [13:0]        adjust_cap;
   logic [13:0]        jog_step;
   logic [14:0]        v_lo;
   logic [14:0]        v_hi;
   logic signed [15:0] h_lo;
   logic signed [15:0] h_hi;

   int   auto_v;
   int   auto_h;
   int   drive_v;
   int   drive_h;
   logic manual;
   int   errors;

   dalt_rsp_type pending_targets[$];

   // capped move for a quadrant difference, -1 when the axis holds
   function automatic int axis_move(input int d);
      int mag;
      int adj;
      mag = (d < 0) ? -d : d;
      if (mag <= 2 * int'(light_thr)) return -1;
      adj = 5 * mag;
      return (adj > int'(adjust_cap)) ? int'(adjust_cap) : adj;
   endfunction

   function automatic dalt_rsp_type advance_tracker(input dalt_req_type item);
      dalt_rsp_type res;
      int tl, tr, bl, br;
      int dv, dh, adj, nv, nh, t;
      int vlo, vhi, hlo, hhi, step;
      logic moved;
      vlo = int'(v_lo);
      vhi = int'(v_hi);
      hlo = int'(h_lo);
      hhi = int'(h_hi);
      step = int'(jog_step);
      tl = int'(item.lux_top_left);
      tr = int'(item.lux_top_right);
      bl = int'(item.lux_bottom_left);
      br = int'(item.lux_bottom_right);
      moved = 1'b0;
      case (item.command)
         CMD_SAMPLE: if (!manual) begin
            dv = (bl + br) - (tl + tr);
            dh = (tr + br) - (tl + bl);
            adj = axis_move(dv);
            if (adj >= 0) begin
               nv = auto_v;
               if (dv > 0 && auto_v < vhi) nv = nv + adj;
               else if (dv < 0 && auto_v > vlo) nv = nv - adj;
               // vertical limits are exclusive
               if (nv > vlo && nv < vhi) auto_v = nv;
            end
            adj = axis_move(dh);
            if (adj >= 0) begin
               nh = auto_h;
               if (dh > 0 && auto_h < hhi) nh = nh + adj;
               else if (dh < 0 && auto_h > hlo) nh = nh - adj;
               if (nh >= hlo && nh <= hhi) auto_h = nh;
            end
            drive_v = auto_v;
            drive_h = auto_h;
            moved = 1'b1;
         end
         CMD_MODE: manual = !manual;
         CMD_RIGHT: if (manual) begin
            t = drive_h + step;
            drive_h = (t < hhi) ? t : hhi;
            moved = 1'b1;
         end
         CMD_LEFT: if (manual) begin
            t = drive_h - step;
            drive_h = (t > hlo) ? t : hlo;
            moved = 1'b1;
         end
         CMD_UP: if (manual) begin
            t = drive_v + step;
            drive_v = (t < vhi) ? t : vhi;
            moved = 1'b1;
         end
         CMD_DOWN: if (manual) begin
            t = drive_v - step;
            drive_v = (t > vlo) ? t : vlo;
            moved = 1'b1;
         end
         default: ;
      endcase
      res.move_issued = moved;
      res.vert_target = drive_v[VertWidth-1:0];
      res.horiz_target = drive_h[HorzWidth-1:0];
      res.manual_mode = manual;
      return res;
   endfunction

   always @(posedge clock) begin
      dalt_rsp_type want;
      if (reset) begin
         light_thr = 16'd5;
         adjust_cap = 14'd500;
         jog_step = 14'd500;
         v_lo = 15'd0;
         v_hi = 15'd9000;
         h_lo = -16'sd9000;
         h_hi = 16'sd9000;
         auto_v = 9000;
         auto_h = 0;
         drive_v = 9000;
         drive_h = 0;
         manual = 1'b0;
         errors = 0;
         pending_targets.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_LIGHT_THRESHOLD: light_thr = csr_wdata;
               REG_MAX_ADJUST:      adjust_cap = csr_wdata[13:0];
               REG_MANUAL_STEP:     jog_step = csr_wdata[13:0];
               REG_VERT_MIN:        v_lo = csr_wdata[14:0];
               REG_VERT_MAX:        v_hi = csr_wdata[14:0];
               REG_HORIZ_MIN:       h_lo = signed'(csr_wdata);
               REG_HORIZ_MAX:       h_hi = signed'(csr_wdata);
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_targets.size() == 0) begin
               $error("result item with no request item open");
               errors++;
            end else begin
               want = pending_targets.pop_front();
               if (rsp_data.move_issued !== want.move_issued) begin
                  $error("move_issued: expected %0d, got %0d",
                         want.move_issued, rsp_data.move_issued);
                  errors++;
               end
               if (rsp_data.vert_target !== want.vert_target) begin
                  $error("vert_target: expected %0d, got %0d",
                         want.vert_target, rsp_data.vert_target);
                  errors++;
               end
               if (rsp_data.horiz_target !== want.horiz_target) begin
                  $error("horiz_target: expected %0d, got %0d",
                         want.horiz_target, rsp_data.horiz_target);
                  errors++;
               end
               if (rsp_data.manual_mode !== want.manual_mode) begin
                  $error("manual_mode: expected %0d, got %0d",
                         want.manual_mode, rsp_data.manual_mode);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) pending_targets.push_back(advance_tracker(req_data));
      end
      open_items <= pending_targets.size();
      fail_count <= errors;
   end

endmodule

/* sim/tb_dual_axis_light_tracker.sv */
// ----------------------------------------------------------------------------
// tb_dual_axis_light_tracker
// Drives lux samples, mode presses and jogs into the tracker in random
// bursts under several register settings, stalls the result side, and
// takes the verdict from the checker that sits beside the block.
// ----------------------------------------------------------------------------
module tb_dual_axis_light_tracker;
   import dalt_pkg::*;

   localparam logic [CmdWidth-1:0] CMD_SPARE_A = 3'd6;
   localparam logic [CmdWidth-1:0] CMD_SPARE_B = 3'd7;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   dalt_req_type            req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   dalt_rsp_type            rsp_data;
   logic                    csr_write = 1'b0;
   logic [CsrIdxWidth-1:0]  csr_index = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;
   int                      open_items;
   int                      fail_count;

   int burst_left = 0;
   int hold_calls = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int rx_cycle = 0;
   int rx_style = 0;

   dual_axis_light_tracker dut (.*);
   dalt_checker tracker_check (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side: random stall styles, plus a long hold-off on request
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 32 == 0) rx_style <= $urandom_range(0, 3);
      if (hold_seen != hold_calls) begin
         hold_seen <= hold_calls;
         hold_left <= 80;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_style)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) == 1);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= rx_cycle[2];
         endcase
      end
   end

   initial begin
      #4000000;
      $display("tb: failure");
      $finish;
   end

   function automatic dalt_req_type make_req(input logic [CmdWidth-1:0] cmd,
                                             input logic [15:0] tl, tr, bl, br);
      dalt_req_type item;
      item.command = cmd;
      item.lux_top_left = tl;
      item.lux_top_right = tr;
      item.lux_bottom_left = bl;
      item.lux_bottom_right = br;
      return item;
   endfunction

   function automatic dalt_req_type random_item();
      dalt_req_type item;
      int pick;
      logic [15:0] base;
      pick = $urandom_range(0, 99);
      if (pick < 48) item.command = CMD_SAMPLE;
      else if (pick < 60) item.command = CMD_MODE;
      else if (pick < 69) item.command = CMD_RIGHT;
      else if (pick < 78) item.command = CMD_LEFT;
      else if (pick < 87) item.command = CMD_UP;
      else if (pick < 96) item.command = CMD_DOWN;
      else if (pick < 98) item.command = CMD_SPARE_A;
      else item.command = CMD_SPARE_B;
      base = 16'($urandom_range(0, 60000));
      case ($urandom_range(0, 3))
         0: begin
            item.lux_top_left = 16'($urandom);
            item.lux_top_right = 16'($urandom);
            item.lux_bottom_left = 16'($urandom);
            item.lux_bottom_right = 16'($urandom);
         end
         1: begin
            // nearly balanced light, small moves around the threshold
            item.lux_top_left = base + 16'($urandom_range(0, 40));
            item.lux_top_right = base + 16'($urandom_range(0, 40));
            item.lux_bottom_left = base + 16'($urandom_range(0, 40));
            item.lux_bottom_right = base + 16'($urandom_range(0, 40));
         end
         2: begin
            item.lux_top_left = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            item.lux_top_right = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            item.lux_bottom_left = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            item.lux_bottom_right = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         end
         default: begin
            item.lux_top_left = 16'($urandom_range(0, 65535) >> $urandom_range(0, 15));
            item.lux_top_right = 16'($urandom_range(0, 65535) >> $urandom_range(0, 15));
            item.lux_bottom_left = 16'($urandom_range(0, 65535) >> $urandom_range(0, 15));
            item.lux_bottom_right = 16'($urandom_range(0, 65535) >> $urandom_range(0, 15));
         end
      endcase
      return item;
   endfunction

   task automatic offer(input dalt_req_type item);
      req_data <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 10);
      end
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_items != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      if (open_items != 0) $error("%0d items still open", open_items);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_reg(input logic [CsrIdxWidth-1:0] idx, input int value);
      csr_index <= idx;
      csr_wdata <= value[CsrDataWidth-1:0];
      @(posedge clock);
   endtask

   task automatic load_settings(input int thr, cap, jog, vlo, vhi, hlo, hhi);
      csr_write <= 1'b1;
      put_reg(REG_LIGHT_THRESHOLD, thr);
      put_reg(REG_MAX_ADJUST, cap);
      put_reg(REG_MANUAL_STEP, jog);
      put_reg(REG_VERT_MIN, vlo);
      put_reg(REG_VERT_MAX, vhi);
      put_reg(REG_HORIZ_MIN, hlo);
      put_reg(REG_HORIZ_MAX, hhi);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default settings
      offer(make_req(CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      offer(make_req(CMD_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      offer(make_req(CMD_SAMPLE, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF));
      offer(make_req(CMD_SAMPLE, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000));
      offer(make_req(CMD_SAMPLE, 16'd0, 16'd0, 16'd10, 16'd0));
      offer(make_req(CMD_SAMPLE, 16'd0, 16'd0, 16'd11, 16'd0));
      offer(make_req(CMD_SAMPLE, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF));
      offer(make_req(CMD_SAMPLE, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
      offer(make_req(CMD_RIGHT, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
      offer(make_req(CMD_UP, 16'd0, 16'd0, 16'd0, 16'd0));
      offer(make_req(CMD_SPARE_A, 16'd0, 16'd0, 16'd0, 16'd0));
      offer(make_req(CMD_SPARE_B, 16'd0, 16'd0, 16'd0, 16'd0));
      offer(make_req(CMD_MODE, 16'd0, 16'd0, 16'd0, 16'd0));
      offer(make_req(CMD_SAMPLE, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000));
      offer(make_req(CMD_RIGHT, 16'd0, 16'd0, 16'd0, 16'd0));
      offer(make_req(CMD_LEFT, 16'd0, 16'd0, 16'd0, 16'd0));
      offer(make_req(CMD_UP, 16'd0, 16'd0, 16'd0, 16'd0));
      offer(make_req(CMD_UP, 16'd0, 16'd0, 16'd0, 16'd0));
      offer(make_req(CMD_DOWN, 16'd0, 16'd0, 16'd0, 16'd0));
      offer(make_req(CMD_DOWN, 16'd0, 16'd0, 16'd0, 16'd0));
      offer(make_req(CMD_SPARE_B, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      offer(make_req(CMD_MODE, 16'd0, 16'd0, 16'd0, 16'd0));
      offer(make_req(CMD_SAMPLE, 16'd1234, 16'd1234, 16'd1234, 16'd1234));
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: load_settings(0, 9000, 9000, 0, 18000, -18000, 18000);
            1: load_settings(65535, 0, 0, 18000, 0, 18000, -18000);
            default: load_settings($urandom_range(0, 1) ? $urandom_range(0, 20)
                                                        : $urandom_range(0, 65535),
                                   $urandom_range(0, 9000), $urandom_range(0, 9000),
                                   $urandom_range(0, 18000), $urandom_range(0, 18000),
                                   int'($urandom_range(0, 36000)) - 18000,
                                   int'($urandom_range(0, 36000)) - 18000);
         endcase
         for (int n = 0; n < 75; n++) begin
            if (n == 30) hold_calls <= hold_calls + 1;
            offer(random_item());
         end
         drain();
      end

      if (fail_count == 0 && open_items == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
